// File: hw/rtl/swr_pkg.sv
// Shared types and constants of the sliding window receiver.
package swr_pkg;

	localparam int WINDOW_MAX_DEF = 64;

	// Width and reset value of the window size register.
	localparam int             WS_W     = 7;
	localparam logic [WS_W-1:0] WS_RESET = 7'd16;

	// Packet type codes.
	localparam logic [1:0] TYPE_START = 2'd0;
	localparam logic [1:0] TYPE_END   = 2'd1;
	localparam logic [1:0] TYPE_DATA  = 2'd2;
	localparam logic [1:0] TYPE_ACK   = 2'd3;

	// Operations of the shared sequence arithmetic unit.
	localparam logic ALU_OFFSET = 1'b0;
	localparam logic ALU_INC    = 1'b1;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] seq_num;
		logic [31:0] header_checksum;
		logic [31:0] payload_crc;
		logic        length_ok;
	} in_item_t;

	typedef struct packed {
		logic [31:0] ack_seq;
		logic        new_data;
		logic [31:0] data_seq;
		logic        transfer_done;
		logic [31:0] packet_count;
	} out_item_t;

endpackage

// File: hw/rtl/swr_alu.sv
// Shared 33-bit sequence adder: window offset and expected sequence increment.
module swr_alu import swr_pkg::*; (
	input  logic        op,
	input  logic [31:0] seq,
	input  logic [31:0] expected,
	output logic [32:0] result
);

	logic [32:0] opa;
	logic [32:0] opb;
	logic        cin;

	always_comb begin
		unique case (op)
			ALU_OFFSET: begin
				// seq - expected; bit 32 set means seq lies below expected.
				opa = {1'b0, seq};
				opb = ~{1'b0, expected};
				cin = 1'b1;
			end
			ALU_INC: begin
				opa = {1'b0, expected};
				opb = 33'd0;
				cin = 1'b1;
			end
			default: begin
				opa = 33'd0;
				opb = 33'd0;
				cin = 1'b0;
			end
		endcase
	end

	assign result = opa + opb + {32'd0, cin};

endmodule

// File: hw/rtl/sliding_window_receiver_unit.sv
// Top level of the sliding window receiver: sequencer, window state and result register.
//
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    in_data (in_item_t), one packet header
// out       output     out_valid / out_ready  out_data (out_item_t), one ACK item
// cfg       input      cfg_we                 cfg_data, window size register
//
// An item is taken in S_IDLE and checked in the next cycle, in S_CHECK. Dropped and
// ignored items end there. START, END and DATA outside the window go on to S_FIN, which
// moves the result into the output register. A DATA item inside the window passes
// S_MARK, then S_SLIDE, which slides the window past each filled head slot, then S_FIN;
// the slide loop shares the one 33-bit adder that also forms the window offset. The block
// takes the next item while a result waits in the output register. If an earlier result
// is still unclaimed, the sequencer holds the new one until out_ready frees the output
// register. Reset leaves the block disconnected with expected sequence zero, an empty
// bitmap and a window size of 16.
module sliding_window_receiver_unit import swr_pkg::*; #(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  in_item_t        in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output out_item_t       out_data,
	input  logic            cfg_we,
	input  logic [WS_W-1:0] cfg_data
);

	localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam logic [31:0] WMAX32 = 32'(WINDOW_MAX);

	// Sequencer state codes.
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_MARK  = 3'd2;
	localparam logic [2:0] S_SLIDE = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0]            state_q;
	logic                  connected_q;
	logic [31:0]           expected_q;
	logic [WINDOW_MAX-1:0] bitmap_q;
	logic [WS_W-1:0]       window_size_q;
	in_item_t              item_q;
	logic [IDX_W-1:0]      off_q;
	logic                  nd_q;
	out_item_t             res_q;
	out_item_t             res_d;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic        alu_op;
	logic [32:0] alu_result;
	logic [31:0] ws_ext;
	logic [31:0] ws_eff;
	logic        crc_ok;
	logic        below;
	logic        beyond;
	logic        out_free;

	// One adder serves both the offset of a DATA item and each window slide step.
	assign alu_op = (state_q == S_SLIDE) ? ALU_INC : ALU_OFFSET;

	swr_alu u_alu (
		.op       (alu_op),
		.seq      (item_q.seq_num),
		.expected (expected_q),
		.result   (alu_result)
	);

	// The usable window is the register value capped at the bitmap size.
	assign ws_ext = {{(32 - WS_W){1'b0}}, window_size_q};
	assign ws_eff = (ws_ext < WMAX32) ? ws_ext : WMAX32;

	assign crc_ok   = (item_q.payload_crc == item_q.header_checksum);
	assign below    = alu_result[32];
	assign beyond   = (alu_result[31:0] >= ws_eff);
	assign out_free = !out_valid_q || out_ready;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WS_RESET;
		end else if (cfg_we) begin
			window_size_q <= cfg_data;
		end
	end

	// Sequencer and window state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			connected_q <= 1'b0;
			expected_q  <= 32'd0;
			bitmap_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= S_IDLE;
					unique case (item_q.req_type)
						TYPE_START: begin
							if (!connected_q) begin
								connected_q <= 1'b1;
								expected_q  <= 32'd0;
								bitmap_q    <= '0;
								state_q     <= S_FIN;
							end
						end
						TYPE_END: begin
							// END is refused while packet zero is missing but later ones wait.
							if (connected_q && crc_ok &&
							    !((expected_q == 32'd0) && (|bitmap_q))) begin
								connected_q <= 1'b0;
								expected_q  <= 32'd0;
								bitmap_q    <= '0;
								state_q     <= S_FIN;
							end
						end
						TYPE_DATA: begin
							if (connected_q && item_q.length_ok && crc_ok) begin
								if (below || beyond) begin
									state_q <= S_FIN;
								end else begin
									state_q <= S_MARK;
								end
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_MARK: begin
					bitmap_q[off_q] <= 1'b1;
					state_q         <= S_SLIDE;
				end
				S_SLIDE: begin
					// Slide one sequence number per cycle while the head slot is filled.
					if (bitmap_q[0]) begin
						expected_q <= alu_result[31:0];
						bitmap_q   <= bitmap_q >> 1;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The pending result is formed at the check and, for DATA inside the window, completed when the slide ends.
	always_comb begin
		res_d = res_q;
		if (state_q == S_CHECK) begin
			res_d = '0;
			unique case (item_q.req_type)
				TYPE_START: begin
					res_d.ack_seq = item_q.seq_num;
				end
				TYPE_END: begin
					res_d.ack_seq       = item_q.seq_num;
					res_d.transfer_done = 1'b1;
					res_d.packet_count  = expected_q;
				end
				TYPE_DATA: begin
					res_d.ack_seq = expected_q;
				end
				default: begin
					res_d.ack_seq = 32'd0;
				end
			endcase
		end else if (state_q == S_SLIDE && !bitmap_q[0]) begin
			res_d.ack_seq  = expected_q;
			res_d.new_data = nd_q;
			res_d.data_seq = nd_q ? item_q.seq_num : 32'd0;
		end
	end

	// Item, offset, new-data flag, pending result and output data registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			item_q <= in_data;
		end
		if (state_q == S_CHECK) begin
			off_q <= alu_result[IDX_W-1:0];
		end
		res_q <= res_d;
		if (state_q == S_MARK) begin
			nd_q <= !bitmap_q[off_q];
		end
		if (state_q == S_FIN && out_free) begin
			out_q <= res_q;
		end
	end

	// The output register holds a result until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule
